// ----- design/ibd_pkg.sv -----
// ----------------------------------------------------------------------------
// ibd_pkg - shared definitions for the interarrival bimodal detector
// Gap class codes, configuration register indexes, field widths and the
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

package ibd_pkg;

  // Default number of gaps held in the class ring.
  localparam int WINDOW_DEF = 32;

  // Field widths fixed by the interface.
  localparam int TS_W    = 64;
  localparam int BOUND_W = 16;
  localparam int THR_W   = 6;
  localparam int COUNT_W = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MIN         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MAX         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_MIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_MAX        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EACH_THRESHOLD  = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [BOUND_W-1:0] LOW_MIN_RST         = 16'd5;
  localparam logic [BOUND_W-1:0] LOW_MAX_RST         = 16'd30;
  localparam logic [BOUND_W-1:0] HIGH_MIN_RST        = 16'd70;
  localparam logic [BOUND_W-1:0] HIGH_MAX_RST        = 16'd150;
  localparam logic [THR_W-1:0]   TOTAL_THRESHOLD_RST = 6'd22;
  localparam logic [THR_W-1:0]   EACH_THRESHOLD_RST  = 6'd3;

  // Class of one gap as held in the ring.
  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_LOW   = 2'd1,
    CLS_HIGH  = 2'd2
  } gap_cls_t;

endpackage

`default_nettype wire

// ----- design/interarrival_bimodal_detector.sv -----
// ----------------------------------------------------------------------------
// interarrival_bimodal_detector - packet gap bimodality detector
// Classifies the gap between successive timestamps into a low or a high
// cluster, keeps running cluster counts over a ring of WINDOW gaps and
// raises an alert when both clusters are well populated.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+---------------------------------
//  in_      | input     | in_valid/in_stall | in_timestamp_ms[63:0]
//  out_     | output    | out_valid/out_stall | out_alert, out_low_count,
//           |           |                   | out_high_count
//  cfg_     | input     | cfg_we            | cfg_index[2:0], cfg_data[15:0]
//
// One request is taken every cycle while in_stall is low; its result
// appears in the output register on the next edge. The class ring is a
// memory read in advance at the slot that the next request will overwrite,
// which keeps the rate at one. rst_n clears the timestamp, counts, slot, fill
// count and the per-slot valid bits at once, so no clearing pass is needed.
// in_stall is raised only while a held result is stalled at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module interarrival_bimodal_detector #(
  parameter int WINDOW = ibd_pkg::WINDOW_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [ibd_pkg::TS_W-1:0]       in_timestamp_ms,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_alert,
  output logic [ibd_pkg::COUNT_W-1:0]         out_low_count,
  output logic [ibd_pkg::COUNT_W-1:0]         out_high_count,
  input  wire logic                           cfg_we,
  input  wire logic [ibd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ibd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int CMP_W  = (CNT_W + 1 > ibd_pkg::THR_W) ? CNT_W + 1 : ibd_pkg::THR_W;

  // Configuration registers.
  logic [ibd_pkg::BOUND_W-1:0] low_min_r, low_max_r, high_min_r, high_max_r;
  logic [ibd_pkg::THR_W-1:0]   total_thr_r, each_thr_r;

  // Detector state.
  logic [ibd_pkg::TS_W-1:0] last_time_r;
  logic [SLOT_W-1:0]        slot_r, slot_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic [CNT_W-1:0]         low_r, low_nxt;
  logic [CNT_W-1:0]         high_r, high_nxt;

  // Class ring and its one-ahead read.
  ibd_pkg::gap_cls_t ring_mem [WINDOW];
  logic [WINDOW-1:0] ring_vld_r;
  ibd_pkg::gap_cls_t rd_cls_r;
  logic              rd_vld_r;
  logic              byp_r;
  ibd_pkg::gap_cls_t byp_cls_r;

  // Output register.
  logic                        out_valid_r;
  logic                        out_alert_r;
  logic [ibd_pkg::COUNT_W-1:0] out_low_r, out_high_r;

  logic                     in_acc;
  logic                     do_gap;
  logic [ibd_pkg::TS_W-1:0] gap;
  ibd_pkg::gap_cls_t        new_cls;
  ibd_pkg::gap_cls_t        old_cls;
  logic [CNT_W-1:0]         low_step, high_step;
  logic [CNT_W-1:0]         fill_inc;
  logic [SLOT_W-1:0]        slot_inc;
  logic [CMP_W-1:0]         sum_cmp;
  logic                     alert;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign do_gap   = in_acc && (last_time_r != '0);

  always_comb begin
    gap = in_timestamp_ms - last_time_r;

    // The low cluster wins when both ranges match.
    if (gap >= ibd_pkg::TS_W'(low_min_r) && gap <= ibd_pkg::TS_W'(low_max_r)) begin
      new_cls = ibd_pkg::CLS_LOW;
    end else if (gap >= ibd_pkg::TS_W'(high_min_r) &&
                 gap <= ibd_pkg::TS_W'(high_max_r)) begin
      new_cls = ibd_pkg::CLS_HIGH;
    end else begin
      new_cls = ibd_pkg::CLS_OTHER;
    end

    // A slot written on the previous edge is taken from the bypass; a slot
    // never written since reset counts as the other class.
    if (byp_r) begin
      old_cls = byp_cls_r;
    end else if (rd_vld_r) begin
      old_cls = rd_cls_r;
    end else begin
      old_cls = ibd_pkg::CLS_OTHER;
    end

    low_step = low_r;
    if (old_cls == ibd_pkg::CLS_LOW && low_r != '0) begin
      low_step = low_step - CNT_W'(1);
    end
    if (new_cls == ibd_pkg::CLS_LOW) begin
      low_step = low_step + CNT_W'(1);
    end

    high_step = high_r;
    if (old_cls == ibd_pkg::CLS_HIGH && high_r != '0) begin
      high_step = high_step - CNT_W'(1);
    end
    if (new_cls == ibd_pkg::CLS_HIGH) begin
      high_step = high_step + CNT_W'(1);
    end

    fill_inc = (fill_r == CNT_W'(WINDOW)) ? fill_r : fill_r + CNT_W'(1);
    slot_inc = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
    sum_cmp  = CMP_W'(low_step) + CMP_W'(high_step);

    alert = do_gap && (fill_inc == CNT_W'(WINDOW)) &&
            (sum_cmp > CMP_W'(total_thr_r)) &&
            (CMP_W'(low_step) > CMP_W'(each_thr_r)) &&
            (CMP_W'(high_step) > CMP_W'(each_thr_r));

    low_nxt  = low_r;
    high_nxt = high_r;
    fill_nxt = fill_r;
    slot_nxt = slot_r;
    if (do_gap) begin
      low_nxt  = low_step;
      high_nxt = high_step;
      if (alert) begin
        fill_nxt = '0;
        slot_nxt = '0;
      end else begin
        fill_nxt = fill_inc;
        slot_nxt = slot_inc;
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_min_r   <= ibd_pkg::LOW_MIN_RST;
      low_max_r   <= ibd_pkg::LOW_MAX_RST;
      high_min_r  <= ibd_pkg::HIGH_MIN_RST;
      high_max_r  <= ibd_pkg::HIGH_MAX_RST;
      total_thr_r <= ibd_pkg::TOTAL_THRESHOLD_RST;
      each_thr_r  <= ibd_pkg::EACH_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ibd_pkg::REG_LOW_MIN:         low_min_r   <= cfg_data;
        ibd_pkg::REG_LOW_MAX:         low_max_r   <= cfg_data;
        ibd_pkg::REG_HIGH_MIN:        high_min_r  <= cfg_data;
        ibd_pkg::REG_HIGH_MAX:        high_max_r  <= cfg_data;
        ibd_pkg::REG_TOTAL_THRESHOLD: total_thr_r <= cfg_data[ibd_pkg::THR_W-1:0];
        ibd_pkg::REG_EACH_THRESHOLD:  each_thr_r  <= cfg_data[ibd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Detector state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      slot_r      <= '0;
      fill_r      <= '0;
      low_r       <= '0;
      high_r      <= '0;
      ring_vld_r  <= '0;
      rd_vld_r    <= 1'b0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        last_time_r <= in_timestamp_ms;
      end
      slot_r <= slot_nxt;
      fill_r <= fill_nxt;
      low_r  <= low_nxt;
      high_r <= high_nxt;
      if (do_gap) begin
        ring_vld_r[slot_r] <= 1'b1;
      end
      rd_vld_r <= ring_vld_r[slot_nxt];
      byp_r    <= do_gap && (slot_nxt == slot_r);
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Ring memory: at most one write and one registered read each cycle.
  always_ff @(posedge clk) begin
    if (do_gap) begin
      ring_mem[slot_r] <= new_cls;
    end
    rd_cls_r  <= ring_mem[slot_nxt];
    byp_cls_r <= new_cls;
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_alert_r <= alert;
      out_low_r   <= ibd_pkg::COUNT_W'(low_nxt);
      out_high_r  <= ibd_pkg::COUNT_W'(high_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_alert      = out_alert_r;
  assign out_low_count  = out_low_r;
  assign out_high_count = out_high_r;

endmodule

`default_nettype wire

// ----- test/interarrival_bimodal_detector_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interarrival_bimodal_detector_tb - self-checking bench for the gap detector
// Drives streams of packet timestamps and keeps its own model of the class
// ring, the running cluster counts and the alert rule. Every result is
// checked field by field against the model. Boundary gaps, overlapping and
// inverted bounds, timestamp wrap and zero timestamps are driven first. Then
// randomised traffic runs under several register settings, with random
// back-pressure on both channels in part of the runs.
// ----------------------------------------------------------------------------

module interarrival_bimodal_detector_tb;

  localparam int WINDOW      = ibd_pkg::WINDOW_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [ibd_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [ibd_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                        alert;
    logic [ibd_pkg::COUNT_W-1:0] low_count;
    logic [ibd_pkg::COUNT_W-1:0] high_count;
  } bimodal_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [ibd_pkg::TS_W-1:0]       in_timestamp_ms = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_alert;
  logic [ibd_pkg::COUNT_W-1:0]    out_low_count;
  logic [ibd_pkg::COUNT_W-1:0]    out_high_count;
  logic                           cfg_we = 1'b0;
  logic [ibd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ibd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  interarrival_bimodal_detector dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_timestamp_ms (in_timestamp_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_alert       (out_alert),
    .out_low_count   (out_low_count),
    .out_high_count  (out_high_count),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Register copies used by the model.
  logic [ibd_pkg::BOUND_W-1:0] low_min_q, low_max_q, high_min_q, high_max_q;
  logic [ibd_pkg::THR_W-1:0]   total_thr_q, each_thr_q;

  // Model state.
  logic [ibd_pkg::TS_W-1:0] prev_ts;
  ibd_pkg::gap_cls_t        class_ring [WINDOW];
  int                       ring_slot;
  int                       ring_fill;
  int                       low_total;
  int                       high_total;

  bimodal_result_t          expected_results [$];
  logic [ibd_pkg::TS_W-1:0] stream_ts;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int holds_asked     = 0;
  int holds_started   = 0;
  int hold_left       = 0;
  int quiet_cycles    = 0;

  int mismatch_count  = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int alerts_seen     = 0;
  int settings_used   = 0;
  bimodal_result_t got_result;
  bimodal_result_t want_result;

  function automatic void reset_model();
    low_min_q   = ibd_pkg::LOW_MIN_RST;
    low_max_q   = ibd_pkg::LOW_MAX_RST;
    high_min_q  = ibd_pkg::HIGH_MIN_RST;
    high_max_q  = ibd_pkg::HIGH_MAX_RST;
    total_thr_q = ibd_pkg::TOTAL_THRESHOLD_RST;
    each_thr_q  = ibd_pkg::EACH_THRESHOLD_RST;
    prev_ts     = '0;
    for (int i = 0; i < WINDOW; i++) class_ring[i] = ibd_pkg::CLS_OTHER;
    ring_slot   = 0;
    ring_fill   = 0;
    low_total   = 0;
    high_total  = 0;
  endfunction

  function automatic bimodal_result_t predict_gap_result(
      input logic [ibd_pkg::TS_W-1:0] ts);
    bimodal_result_t          res;
    logic [ibd_pkg::TS_W-1:0] gap;
    ibd_pkg::gap_cls_t        cls;
    ibd_pkg::gap_cls_t        old_cls;
    res.alert = 1'b0;
    if (prev_ts == '0) begin
      // A stored time of zero means there is no previous packet yet.
      prev_ts = ts;
    end else begin
      gap     = ts - prev_ts;
      prev_ts = ts;
      old_cls = class_ring[ring_slot];
      if (gap >= ibd_pkg::TS_W'(low_min_q) && gap <= ibd_pkg::TS_W'(low_max_q)) begin
        cls = ibd_pkg::CLS_LOW;
      end else if (gap >= ibd_pkg::TS_W'(high_min_q) &&
                   gap <= ibd_pkg::TS_W'(high_max_q)) begin
        cls = ibd_pkg::CLS_HIGH;
      end else begin
        cls = ibd_pkg::CLS_OTHER;
      end
      if (old_cls == ibd_pkg::CLS_LOW && low_total > 0) low_total--;
      if (old_cls == ibd_pkg::CLS_HIGH && high_total > 0) high_total--;
      if (cls == ibd_pkg::CLS_LOW) low_total++;
      if (cls == ibd_pkg::CLS_HIGH) high_total++;
      class_ring[ring_slot] = cls;
      ring_slot = (ring_slot + 1) % WINDOW;
      if (ring_fill < WINDOW) ring_fill++;
      if (ring_fill >= WINDOW && low_total + high_total > total_thr_q &&
          low_total > each_thr_q && high_total > each_thr_q) begin
        res.alert = 1'b1;
        ring_fill = 0;
        ring_slot = 0;
      end
    end
    res.low_count  = low_total[ibd_pkg::COUNT_W-1:0];
    res.high_count = high_total[ibd_pkg::COUNT_W-1:0];
    return res;
  endfunction

  // Mostly gaps inside one of the clusters, so that the window fills with
  // classified gaps and alerts are reached; the rest is noise.
  function automatic logic [ibd_pkg::TS_W-1:0] next_timestamp();
    int unsigned              r;
    logic [ibd_pkg::TS_W-1:0] gap;
    r = $urandom_range(99);
    if (r < 42) begin
      gap = ibd_pkg::TS_W'($urandom_range(low_max_q, low_min_q));
    end else if (r < 84) begin
      gap = ibd_pkg::TS_W'($urandom_range(high_max_q, high_min_q));
    end else if (r < 91) begin
      gap = ibd_pkg::TS_W'($urandom_range(high_max_q + 300, 0));
    end else if (r < 96) begin
      case ($urandom_range(7))
        0: gap = {48'd0, low_min_q} - 64'd1;
        1: gap = {48'd0, low_min_q};
        2: gap = {48'd0, low_max_q};
        3: gap = {48'd0, low_max_q} + 64'd1;
        4: gap = {48'd0, high_min_q} - 64'd1;
        5: gap = {48'd0, high_min_q};
        6: gap = {48'd0, high_max_q};
        default: gap = {48'd0, high_max_q} + 64'd1;
      endcase
    end else if (r < 99) begin
      gap = {$urandom, $urandom};
    end else begin
      // A zero timestamp makes the following packet a recording one.
      stream_ts = '0;
      return stream_ts;
    end
    stream_ts = stream_ts + gap;
    return stream_ts;
  endfunction

  task automatic send_timestamp(input logic [ibd_pkg::TS_W-1:0] ts);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_timestamp_ms <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_gap_result(ts));
    items_sent++;
  endtask

  task automatic send_after_gap(input logic [ibd_pkg::TS_W-1:0] gap);
    stream_ts = stream_ts + gap;
    send_timestamp(stream_ts);
  endtask

  // Stops offering requests and waits until every result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic drive_cfg(input logic [ibd_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [ibd_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_detector(input logic [15:0] lmin, input logic [15:0] lmax,
                                  input logic [15:0] hmin, input logic [15:0] hmax,
                                  input logic [15:0] tot, input logic [15:0] each_v);
    drain_results();
    repeat (2) @(posedge clk);
    drive_cfg(ibd_pkg::REG_LOW_MIN, lmin);
    drive_cfg(ibd_pkg::REG_LOW_MAX, lmax);
    drive_cfg(ibd_pkg::REG_HIGH_MIN, hmin);
    drive_cfg(ibd_pkg::REG_HIGH_MAX, hmax);
    drive_cfg(ibd_pkg::REG_TOTAL_THRESHOLD, tot);
    drive_cfg(ibd_pkg::REG_EACH_THRESHOLD, each_v);
    // Writes to unused indexes must leave every register alone.
    drive_cfg((settings_used % 2) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
    cfg_we      <= 1'b0;
    low_min_q   = lmin;
    low_max_q   = lmax;
    high_min_q  = hmin;
    high_max_q  = hmax;
    total_thr_q = tot[ibd_pkg::THR_W-1:0];
    each_thr_q  = each_v[ibd_pkg::THR_W-1:0];
    settings_used++;
  endtask

  task automatic test_edge_gaps();
    stream_ts = 64'd1000;
    send_timestamp(stream_ts);
    send_after_gap(64'd5);
    send_after_gap(64'd30);
    send_after_gap(64'd4);
    send_after_gap(64'd31);
    send_after_gap(64'd70);
    send_after_gap(64'd150);
    send_after_gap(64'd151);
    send_after_gap(64'd69);
    send_after_gap(64'd0);
    // Going backwards wraps the gap to a huge value.
    send_after_gap(-64'sd10);
    stream_ts = '0;
    send_timestamp(stream_ts);
    stream_ts = '1;
    send_timestamp(stream_ts);
    // Wraps through zero into a low cluster gap.
    stream_ts = 64'd4;
    send_timestamp(stream_ts);
    stream_ts = 64'h8000_0000_0000_0000;
    send_timestamp(stream_ts);
    drain_results();
  endtask

  task automatic test_overlapping_bounds();
    program_detector(16'd10, 16'd100, 16'd50, 16'd200, 16'd22, 16'd3);
    send_after_gap(64'd60);
    send_after_gap(64'd150);
    send_after_gap(64'd100);
    send_after_gap(64'd49);
    send_after_gap(64'd201);
    drain_results();
  endtask

  task automatic test_inverted_bounds();
    program_detector(16'd40, 16'd20, 16'd70, 16'd150, 16'd22, 16'd3);
    send_after_gap(64'd30);
    send_after_gap(64'd20);
    send_after_gap(64'd40);
    send_after_gap(64'd100);
    drain_results();
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_output_holdoff();
    holds_asked++;
    repeat (24) send_timestamp(next_timestamp());
    drain_results();
  endtask

  task automatic test_random_traffic(input int count);
    stream_ts = {$urandom, $urandom};
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(69) == 0) drain_results();
      send_timestamp(next_timestamp());
    end
    drain_results();
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatch_count++;
    $display("mismatch in %s at result %0d: got %0d, expected %0d",
             field, results_checked, got, want);
  endtask

  always @(posedge clk) begin
    if (holds_started != holds_asked) begin
      hold_left     = HOLD_CYCLES;
      holds_started = holds_asked;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      got_result = '{out_alert, out_low_count, out_high_count};
      if (got_result.alert) alerts_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want_result = expected_results.pop_front();
        if (got_result.alert !== want_result.alert)
          report_mismatch("alert", int'(got_result.alert), int'(want_result.alert));
        if (got_result.low_count !== want_result.low_count)
          report_mismatch("low_count", int'(got_result.low_count),
                          int'(want_result.low_count));
        if (got_result.high_count !== want_result.high_count)
          report_mismatch("high_count", int'(got_result.high_count),
                          int'(want_result.high_count));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no progress for %0d cycles", QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 23;
    recv_stall_pct  = 72;
    test_edge_gaps();
    test_overlapping_bounds();
    test_inverted_bounds();
    program_detector(ibd_pkg::LOW_MIN_RST, ibd_pkg::LOW_MAX_RST,
                     ibd_pkg::HIGH_MIN_RST, ibd_pkg::HIGH_MAX_RST,
                     16'(ibd_pkg::TOTAL_THRESHOLD_RST), 16'(ibd_pkg::EACH_THRESHOLD_RST));
    test_random_traffic(170);

    sender_idle_pct = 72;
    recv_stall_pct  = 23;
    program_detector(16'd0, 16'd9, 16'd10, 16'd65535, 16'd0, 16'd0);
    test_random_traffic(170);

    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    program_detector(16'd100, 16'd400, 16'd1000, 16'd3000, 16'd20, 16'd8);
    test_output_holdoff();
    test_random_traffic(150);

    // Upper bits of the threshold data are dropped: 63 and 32, no alert.
    program_detector(16'd1, 16'd3, 16'd4, 16'd8, 16'hFFFF, 16'hFFE0);
    test_random_traffic(130);

    drain_results();
    repeat (4) @(posedge clk);
    $display("covered %0d timestamps and %0d results over %0d register settings",
             items_sent, results_checked, settings_used);
    $display("alerts raised: %0d, mismatches: %0d", alerts_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
